/* rtl/itda_pkg.sv */
// package: shared constants, types and control codes of the decimal ascii converter
`default_nettype none
package itda_pkg;

  localparam int VAL_W         = 32;
  localparam int WIDTH_W       = 6;
  localparam int POS_W         = 5;
  localparam int CHAR_W        = 6;
  localparam int DIG_W         = 4;
  localparam int NDIG          = 10;
  localparam int POS_SPAN      = 32;
  localparam int MAX_WIDTH_DEF = 32;
  localparam int BIT_CNT_W     = $clog2(VAL_W);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(8'h30);
  localparam logic [DIG_W-1:0]  DIG_ADJ_MIN = DIG_W'(5);
  localparam logic [DIG_W-1:0]  DIG_ADJ_ADD = DIG_W'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } itda_state_e;

  typedef struct packed {
    logic clear;
    logic conv;
    logic emit;
  } itda_ctl_t;

endpackage
`default_nettype wire

/* rtl/itda_if.sv */
// interfaces: input and output channels of the decimal ascii converter
`default_nettype none
interface itda_in_if;
  logic                            valid;
  logic                            ready;
  logic [itda_pkg::VAL_W-1:0]      value;
  logic [itda_pkg::WIDTH_W-1:0]    width;
  logic [itda_pkg::WIDTH_W-1:0]    buffer_limit;

  modport source (output valid, value, width, buffer_limit, input ready);
  modport sink   (input valid, value, width, buffer_limit, output ready);
endinterface

interface itda_out_if;
  logic                           valid;
  logic                           ready;
  logic [itda_pkg::POS_W-1:0]     position;
  logic [itda_pkg::CHAR_W-1:0]    digit_char;
  logic                           last;

  modport source (output valid, position, digit_char, last, input ready);
  modport sink   (input valid, position, digit_char, last, output ready);
endinterface
`default_nettype wire

/* rtl/int_to_decimal_ascii.sv */
// Converts a 32-bit unsigned value to ascii decimal digits, least significant digit first,
// placed at positions width-1 down to 0; width 0 selects the natural digit count,
// positions at or above the buffer limit are dropped, and last marks the word at position 0.
// An item passes through an accept step, then a conversion in which a row of ten bcd cells
// takes in the value one bit a cycle (shift and add-3), then a sizing step, then one position
// per cycle as the cells shift their digits down, holding while a word waits on a full output
// register; no position is emitted when the effective width or the buffer limit is zero.
// A new item is accepted only once the previous one has left the cell row; the final
// word may still sit in the output register while the next item is taken.
`default_nettype none
module int_to_decimal_ascii #(
  parameter int MAX_WIDTH = itda_pkg::MAX_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  itda_in_if.sink    in_i,
  itda_out_if.source out_o
);
  import itda_pkg::*;

  localparam int CW      = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W   = (CW > WIDTH_W) ? CW : WIDTH_W;
  localparam int LIM_CAP = (MAX_WIDTH < POS_SPAN) ? MAX_WIDTH : POS_SPAN;

  itda_state_e state_q, state_d;
  logic [BIT_CNT_W-1:0] cnt_q;
  logic [VAL_W-1:0]     val_q;
  logic [CW-1:0]        w_q;
  logic [WIDTH_W-1:0]   lim_q;
  logic [CW-1:0]        pos_q;

  logic                 out_valid_q;
  logic [POS_W-1:0]     out_pos_q;
  logic [CHAR_W-1:0]    out_char_q;
  logic                 out_last_q;

  itda_ctl_t            ctl;
  logic                 accept;
  logic                 emit_now;
  logic                 slot_free;
  logic                 advance;
  logic                 load_out;
  logic [CW-1:0]        w_eff;
  logic [CW-1:0]        w_sat;
  logic [WIDTH_W-1:0]   lim_sat;
  logic [DIG_W-1:0]     nat;

  logic [NDIG:0]        carry;
  logic [DIG_W-1:0]     digs [NDIG+1];

  // cell row
  assign carry[0]   = val_q[VAL_W-1];
  assign digs[NDIG] = '0;

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    itda_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .bit_i   (carry[i]),
      .digit_i (digs[i+1]),
      .bit_o   (carry[i+1]),
      .digit_o (digs[i])
    );
  end

  // natural digit count from the highest nonzero cell
  always_comb begin
    nat = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (digs[i] != '0) begin
        nat = DIG_W'(i + 1);
      end
    end
  end

  assign w_eff = (w_q == '0) ? CW'(nat) : w_q;

  assign w_sat = (CMP_W'(in_i.width) > CMP_W'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                           : CW'(in_i.width);
  assign lim_sat = (CMP_W'(in_i.buffer_limit) > CMP_W'(LIM_CAP)) ? WIDTH_W'(LIM_CAP)
                                                                  : in_i.buffer_limit;

  assign accept    = in_i.valid && in_i.ready;
  assign emit_now  = CMP_W'(pos_q) < CMP_W'(lim_q);
  assign slot_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_CONV;
      ST_CONV: if (cnt_q == BIT_CNT_W'(VAL_W - 1)) state_d = ST_SIZE;
      ST_SIZE: begin
        if (w_eff == '0 || lim_q == '0) state_d = ST_IDLE;
        else                            state_d = ST_EMIT;
      end
      ST_EMIT: if (advance && pos_q == '0) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready = 1'b0;
    ctl        = '0;
    advance    = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        ctl.clear  = in_i.valid;
      end
      ST_CONV: ctl.conv = 1'b1;
      ST_SIZE: ;
      ST_EMIT: begin
        advance  = !emit_now || slot_free;
        load_out = emit_now && slot_free;
        ctl.emit = advance;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q <= in_i.value;
      w_q   <= w_sat;
      lim_q <= lim_sat;
      cnt_q <= '0;
    end
    if (state_q == ST_CONV) begin
      val_q <= {val_q[VAL_W-2:0], 1'b0};
      cnt_q <= cnt_q + BIT_CNT_W'(1);
    end
    if (state_q == ST_SIZE) begin
      pos_q <= w_eff - CW'(1);
    end
    if (advance) begin
      pos_q <= pos_q - CW'(1);
    end
    if (load_out) begin
      out_pos_q  <= POS_W'(pos_q);
      out_char_q <= ASCII_ZERO | CHAR_W'(digs[0]);
      out_last_q <= (pos_q == '0);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.position   = out_pos_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.last       = out_last_q;

  // checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV |-> !carry[NDIG])
    else $error("bcd cell row overflowed");

  a_last_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |-> out_o.position == '0)
    else $error("last word not at position zero");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.digit_char[CHAR_W-1:DIG_W] == 2'b11 &&
                     out_o.digit_char[DIG_W-1:0] <= DIG_W'(9)))
    else $error("digit character out of range");

  a_pos_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (WIDTH_W'(out_o.position) < lim_q))
    else $error("word emitted at or above buffer limit");

  a_size_after_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SIZE |-> $past(state_q) == ST_CONV)
    else $error("sizing step without conversion");

endmodule
`default_nettype wire

/* rtl/itda_cell.sv */
// one bcd digit cell: cleared on accept, add-3 shift step during conversion, digit shift during output
`default_nettype none
module itda_cell (
  input  wire logic                         clk_i,
  input  wire itda_pkg::itda_ctl_t          ctl_i,
  input  wire logic                         bit_i,
  input  wire logic [itda_pkg::DIG_W-1:0]   digit_i,
  output logic                              bit_o,
  output logic [itda_pkg::DIG_W-1:0]        digit_o
);
  import itda_pkg::*;

  logic [DIG_W-1:0] digit_q, digit_d;
  logic [DIG_W-1:0] adj;

  assign adj = (digit_q >= DIG_ADJ_MIN) ? digit_q + DIG_ADJ_ADD : digit_q;

  always_comb begin
    priority if (ctl_i.clear) begin
      digit_d = '0;
    end else if (ctl_i.conv) begin
      digit_d = {adj[DIG_W-2:0], bit_i};
    end else if (ctl_i.emit) begin
      digit_d = digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign bit_o   = adj[DIG_W-1];
  assign digit_o = digit_q;

endmodule
`default_nettype wire
